// ===== hdl/slr_pkg.sv =====
// Shared types and constants for the stereo linear resampler.
// No dependencies; every other file in hdl/ takes names from here.
`default_nettype none

package slr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;

    localparam longint IN_RATE_DEFAULT  = 31910;
    localparam longint OUT_RATE_DEFAULT = 44100;

    // Reset increment: in_rate * 2^16 / out_rate, truncated.
    localparam logic [FRAC_BITS-1:0] INC_RESET =
        FRAC_BITS'((IN_RATE_DEFAULT << FRAC_BITS) / OUT_RATE_DEFAULT);
    localparam logic [FRAC_BITS-1:0] INC_MIN = FRAC_BITS'(4096);

    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [FRAC_BITS-1:0]          t_frac;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEFT,
        ST_RIGHT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/slr_if.sv =====
// Valid/ready channels of the stereo linear resampler: input frames and output words.
// Depends on slr_pkg for the sample type.
`default_nettype none

interface slr_in_if;
    logic             valid;
    logic             ready;
    logic             operation;
    slr_pkg::t_sample left_in;
    slr_pkg::t_sample right_in;

    modport source (output valid, output operation, output left_in, output right_in,
                    input ready);
    modport sink   (input valid, input operation, input left_in, input right_in,
                    output ready);
endinterface

interface slr_out_if;
    logic             valid;
    logic             ready;
    slr_pkg::t_sample left_out;
    slr_pkg::t_sample right_out;
    logic             last_of_run;

    modport source (output valid, output left_out, output right_out, output last_of_run,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/slr_interp.sv =====
// Shared interpolation unit: a + floor((b - a) * frac / 2^16), one channel per use.
// Depends on slr_pkg for sample and fraction widths.
`default_nettype none

module slr_interp (
    input  var slr_pkg::t_sample i_a,
    input  var slr_pkg::t_sample i_b,
    input  var slr_pkg::t_frac   i_frac,
    output var slr_pkg::t_sample o_y
);
    localparam int SB = slr_pkg::SAMPLE_BITS;
    localparam int FB = slr_pkg::FRAC_BITS;

    logic signed [SB:0]       diff;
    logic signed [FB:0]       frac_s;
    logic signed [SB+FB+1:0]  prod;
    logic signed [SB+1:0]     q;
    logic signed [SB+1:0]     sum;

    always_comb begin
        diff   = {i_b[SB-1], i_b} - {i_a[SB-1], i_a};
        frac_s = $signed({1'b0, i_frac});
        prod   = (SB+FB+2)'(diff) * (SB+FB+2)'(frac_s);
        // arithmetic shift keeps the floor
        q      = prod[SB+FB+1:FB];
        sum    = (SB+2)'(i_a) + q;
        o_y    = sum[SB-1:0];
    end

endmodule

`default_nettype wire

// ===== hdl/stereo_linear_resampler.sv =====
// Stereo linear resampler: one frame in, one to sixteen interpolated stereo words out.
// Each output word is formed left, then right (ST_LEFT, ST_RIGHT), through one shared multiplier;
// ST_RIGHT waits while the output register is full, and no new frame is taken until the run ends.
// Restart and first-frame items produce nothing.
// Synchronous active-low reset: no frame held, phase 0, increment 47420, output empty.
// Depends on slr_pkg, slr_if (slr_in_if, slr_out_if) and slr_interp.
`default_nettype none

module stereo_linear_resampler (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var logic                 i_cfg_we,
    input  var slr_pkg::t_frac       i_cfg_data,
    slr_in_if.sink                   i_in_ch,
    slr_out_if.source                o_out_ch
);
    localparam int FB = slr_pkg::FRAC_BITS;

    slr_pkg::t_state  r_state, n_state;
    slr_pkg::t_frac   r_inc;
    slr_pkg::t_frac   r_phase;
    logic             r_held_valid;
    slr_pkg::t_sample r_held_l, r_held_r;
    slr_pkg::t_sample r_cur_l, r_cur_r;
    slr_pkg::t_sample r_left_res;

    logic             r_out_valid;
    slr_pkg::t_sample r_out_l, r_out_r;
    logic             r_out_last;

    logic             in_ready;
    logic             sel_right;
    logic             out_load;
    logic             in_take;
    slr_pkg::t_frac   inc_eff;
    logic [FB:0]      phase_sum;
    logic             run_last;
    slr_pkg::t_sample unit_a, unit_b, unit_y;

    // Clamp the step so one frame never yields more than sixteen words.
    assign inc_eff   = (r_inc < slr_pkg::INC_MIN) ? slr_pkg::INC_MIN : r_inc;
    assign phase_sum = {1'b0, r_phase} + {1'b0, inc_eff};
    // Carry out of the phase add means the next position is past the new frame.
    assign run_last  = phase_sum[FB];
    assign in_take   = i_in_ch.valid && in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            slr_pkg::ST_IDLE: begin
                if (in_take && i_in_ch.operation == slr_pkg::OP_FRAME && r_held_valid) begin
                    n_state = slr_pkg::ST_LEFT;
                end
            end
            slr_pkg::ST_LEFT: begin
                n_state = slr_pkg::ST_RIGHT;
            end
            slr_pkg::ST_RIGHT: begin
                if (out_load) begin
                    n_state = run_last ? slr_pkg::ST_IDLE : slr_pkg::ST_LEFT;
                end
            end
            default: begin
                n_state = slr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        in_ready  = 1'b0;
        sel_right = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            slr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            slr_pkg::ST_LEFT: begin
                sel_right = 1'b0;
            end
            slr_pkg::ST_RIGHT: begin
                sel_right = 1'b1;
                // Hand the word over once the output slot is free or draining.
                out_load  = !r_out_valid || o_out_ch.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Shared multiplier: left channel in ST_LEFT, right channel in ST_RIGHT.
    assign unit_a = sel_right ? r_held_r : r_held_l;
    assign unit_b = sel_right ? r_cur_r  : r_cur_l;

    slr_interp u_interp (
        .i_a    (unit_a),
        .i_b    (unit_b),
        .i_frac (r_phase),
        .o_y    (unit_y)
    );

    // Sequencer, phase and held frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= slr_pkg::ST_IDLE;
            r_inc        <= slr_pkg::INC_RESET;
            r_phase      <= '0;
            r_held_valid <= 1'b0;
            r_held_l     <= '0;
            r_held_r     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_inc <= i_cfg_data;
            end
            if (in_take) begin
                if (i_in_ch.operation == slr_pkg::OP_RESTART) begin
                    // Drop the held frame and rewind the phase.
                    r_phase      <= '0;
                    r_held_valid <= 1'b0;
                    r_held_l     <= '0;
                    r_held_r     <= '0;
                end else if (!r_held_valid) begin
                    // First frame only primes the history.
                    r_held_valid <= 1'b1;
                    r_held_l     <= i_in_ch.left_in;
                    r_held_r     <= i_in_ch.right_in;
                end
            end
            if (out_load) begin
                // Advance the phase; past the frame, wrap and shift history.
                r_phase <= phase_sum[FB-1:0];
                if (run_last) begin
                    r_held_l <= r_cur_l;
                    r_held_r <= r_cur_r;
                end
            end
        end
    end

    // Frame under work and the left half of the pending word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cur_l <= i_in_ch.left_in;
            r_cur_r <= i_in_ch.right_in;
        end
        if (r_state == slr_pkg::ST_LEFT) begin
            r_left_res <= unit_y;
        end
    end

    // Output register: hold the word until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_l    <= r_left_res;
            r_out_r    <= unit_y;
            r_out_last <= run_last;
        end
    end

    assign i_in_ch.ready        = in_ready;
    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.left_out    = r_out_l;
    assign o_out_ch.right_out   = r_out_r;
    assign o_out_ch.last_of_run = r_out_last;

`ifndef NO_ASSERTIONS
    a_more_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && !run_last) |=> (r_state == slr_pkg::ST_LEFT))
        else $error("run did not continue after a non-final word");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && run_last) |=>
            (r_state == slr_pkg::ST_IDLE && r_held_l == $past(r_cur_l)
             && r_held_r == $past(r_cur_r)))
        else $error("history not advanced at end of run");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!out_load && !(in_take && i_in_ch.operation == slr_pkg::OP_RESTART))
            |=> $stable(r_phase))
        else $error("phase moved without an output word or restart");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == slr_pkg::ST_RIGHT && (!r_out_valid || o_out_ch.ready)))
        else $error("output word overwritten before it was taken");
`endif

endmodule

`default_nettype wire
